// ===== hw/rtl/lrast_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lrast_pkg
// Shared types and codes of the line rasterizer: coordinate, offset and mask
// widths, and the command operation codes.
// ============================================================================
package lrast_pkg;

    // Field widths fixed by the item formats, and the error term width.
    localparam int X_W    = 10;
    localparam int Y_W    = 9;
    localparam int OFF_W  = 15;
    localparam int MASK_W = 8;
    localparam int ERR_W  = 12;

    typedef logic [X_W-1:0]    t_xcoord;
    typedef logic [Y_W-1:0]    t_ycoord;
    typedef logic [OFF_W-1:0]  t_offset;
    typedef logic [MASK_W-1:0] t_mask;

    // Command operation codes.
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

endpackage

// ===== hw/rtl/lrast_cmd_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lrast_cmd_if
// Command channel: a start item with both endpoints, or an advance item.
// ============================================================================
interface lrast_cmd_if;
    import lrast_pkg::*;

    logic    valid;
    logic    ready;
    logic    operation;
    t_xcoord x_start;
    t_ycoord y_start;
    t_xcoord x_end;
    t_ycoord y_end;

    modport source (
        output valid, operation, x_start, y_start, x_end, y_end,
        input  ready
    );
    modport sink (
        input  valid, operation, x_start, y_start, x_end, y_end,
        output ready
    );
endinterface

// ===== hw/rtl/lrast_pix_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lrast_pix_if
// Pixel channel: one drawn pixel with its framebuffer byte offset and mask.
// ============================================================================
interface lrast_pix_if;
    import lrast_pkg::*;

    logic    valid;
    logic    ready;
    t_xcoord pixel_x;
    t_ycoord pixel_y;
    t_offset byte_offset;
    t_mask   bit_mask;
    logic    last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, byte_offset, bit_mask, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, byte_offset, bit_mask, last_pixel,
        output ready
    );
endinterface

// ===== hw/rtl/line_rasterizer_interleaved_fb.sv =====
`timescale 1ns / 1ps
// Latency: a result appears in the cycle after its advance item is accepted.
// Throughput: one item per cycle; the Bresenham step is a single pass of
// adds and compares on the state registers, and the output register frees
// the command side whenever its item is taken or absent.
// Reset (synchronous, active low) leaves the block idle with no pending item.
// ============================================================================
// line_rasterizer_interleaved_fb
// Bresenham line rasterizer in all octants that emits one pixel per advance
// item while a line is in progress, with its byte offset and bit mask in a
// four-bank interleaved monochrome framebuffer.
// ============================================================================
module line_rasterizer_interleaved_fb #(
    parameter int ROW_BYTES   = 90,
    parameter int BANK_STRIDE = 8192
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lrast_cmd_if.sink    i_cmd,
    lrast_pix_if.source  o_pix
);
    import lrast_pkg::*;

    // Line state.
    logic                    r_busy, n_busy;
    t_xcoord                 r_cur_x, n_cur_x;
    t_ycoord                 r_cur_y, n_cur_y;
    t_xcoord                 r_tgt_x, n_tgt_x;
    t_ycoord                 r_tgt_y, n_tgt_y;
    logic                    r_x_neg, n_x_neg;
    logic                    r_y_neg, n_y_neg;
    logic [X_W-1:0]          r_dx, n_dx;
    logic [X_W-1:0]          r_dy, n_dy;
    logic signed [ERR_W-1:0] r_err, n_err;

    // Output register.
    logic    r_out_valid, n_out_valid;
    t_xcoord r_px;
    t_ycoord r_py;
    t_offset r_off;
    t_mask   r_mask;
    logic    r_last;

    logic                  w_in_acc;
    logic                  w_emit;
    logic                  w_last;
    t_offset               w_offset;
    t_mask                 w_mask;
    logic signed [ERR_W:0] w_e2;
    logic signed [ERR_W:0] w_dx_s;
    logic signed [ERR_W:0] w_dy_s;
    logic signed [ERR_W:0] w_err_sum;
    logic                  w_step_x;
    logic                  w_step_y;

    // The command side is free whenever the output register empties this cycle.
    assign i_cmd.ready = !r_out_valid || o_pix.ready;
    assign w_in_acc    = i_cmd.valid && i_cmd.ready;
    assign w_emit      = w_in_acc && (i_cmd.operation == OP_ADVANCE) && r_busy;
    assign w_last      = (r_cur_x == r_tgt_x) && (r_cur_y == r_tgt_y);

    // Address of the current pixel.
    lrast_addr #(
        .ROW_BYTES   (ROW_BYTES),
        .BANK_STRIDE (BANK_STRIDE)
    ) u_addr (
        .i_x      (r_cur_x),
        .i_y      (r_cur_y),
        .o_offset (w_offset),
        .o_mask   (w_mask)
    );

    // Bresenham decision on the doubled error term.
    assign w_e2      = {r_err, 1'b0};
    assign w_dx_s    = $signed({{(ERR_W + 1 - X_W){1'b0}}, r_dx});
    assign w_dy_s    = $signed({{(ERR_W + 1 - X_W){1'b0}}, r_dy});
    assign w_step_x  = w_e2 >= -w_dy_s;
    assign w_step_y  = w_e2 <= w_dx_s;
    assign w_err_sum = $signed({r_err[ERR_W-1], r_err})
                       - (w_step_x ? w_dy_s : '0)
                       + (w_step_y ? w_dx_s : '0);

    // Next line state.
    always_comb begin
        n_busy  = r_busy;
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        n_tgt_x = r_tgt_x;
        n_tgt_y = r_tgt_y;
        n_x_neg = r_x_neg;
        n_y_neg = r_y_neg;
        n_dx    = r_dx;
        n_dy    = r_dy;
        n_err   = r_err;
        if (w_in_acc && (i_cmd.operation == OP_START)) begin
            // A start loads a new line and abandons any line in progress.
            n_busy  = 1'b1;
            n_cur_x = i_cmd.x_start;
            n_cur_y = i_cmd.y_start;
            n_tgt_x = i_cmd.x_end;
            n_tgt_y = i_cmd.y_end;
            n_x_neg = !(i_cmd.x_start < i_cmd.x_end);
            n_y_neg = !(i_cmd.y_start < i_cmd.y_end);
            n_dx    = (i_cmd.x_start > i_cmd.x_end) ? (i_cmd.x_start - i_cmd.x_end)
                                                    : (i_cmd.x_end - i_cmd.x_start);
            n_dy    = X_W'((i_cmd.y_start > i_cmd.y_end) ? (i_cmd.y_start - i_cmd.y_end)
                                                         : (i_cmd.y_end - i_cmd.y_start));
            n_err   = $signed(ERR_W'(n_dx)) - $signed(ERR_W'(n_dy));
        end else if (w_emit) begin
            if (w_last) begin
                n_busy = 1'b0;
            end else begin
                n_err = w_err_sum[ERR_W-1:0];
                if (w_step_x) begin
                    n_cur_x = r_x_neg ? (r_cur_x - 1'b1) : (r_cur_x + 1'b1);
                end
                if (w_step_y) begin
                    n_cur_y = r_y_neg ? (r_cur_y - 1'b1) : (r_cur_y + 1'b1);
                end
            end
        end
    end

    // Output register occupancy.
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (o_pix.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control and line state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_tgt_x     <= '0;
            r_tgt_y     <= '0;
            r_x_neg     <= 1'b0;
            r_y_neg     <= 1'b0;
            r_dx        <= '0;
            r_dy        <= '0;
            r_err       <= '0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_tgt_x     <= n_tgt_x;
            r_tgt_y     <= n_tgt_y;
            r_x_neg     <= n_x_neg;
            r_y_neg     <= n_y_neg;
            r_dx        <= n_dx;
            r_dy        <= n_dy;
            r_err       <= n_err;
        end
    end

    // Result payload is captured with each emitted pixel.
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_px   <= r_cur_x;
            r_py   <= r_cur_y;
            r_off  <= w_offset;
            r_mask <= w_mask;
            r_last <= w_last;
        end
    end

    assign o_pix.valid       = r_out_valid;
    assign o_pix.pixel_x     = r_px;
    assign o_pix.pixel_y     = r_py;
    assign o_pix.byte_offset = r_off;
    assign o_pix.bit_mask    = r_mask;
    assign o_pix.last_pixel  = r_last;
endmodule

// ===== hw/rtl/lrast_addr.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lrast_addr
// Framebuffer address of a pixel in the four-bank interleaved layout:
// (y/4)*ROW_BYTES + (y mod 4)*BANK_STRIDE + x/8, wrapped to the offset width,
// and the one-hot mask with the leftmost pixel in the MSB.
// ============================================================================
module lrast_addr #(
    parameter int ROW_BYTES   = 90,
    parameter int BANK_STRIDE = 8192
) (
    input  lrast_pkg::t_xcoord i_x,
    input  lrast_pkg::t_ycoord i_y,
    output lrast_pkg::t_offset o_offset,
    output lrast_pkg::t_mask   o_mask
);
    import lrast_pkg::*;

    t_offset w_row_part;
    t_offset w_bank_part;
    t_offset w_byte_part;

    // All terms are taken modulo the offset width, so truncated operands suffice.
    assign w_row_part  = OFF_W'(i_y[Y_W-1:2]) * OFF_W'(ROW_BYTES);
    assign w_bank_part = OFF_W'(i_y[1:0]) * OFF_W'(BANK_STRIDE);
    assign w_byte_part = OFF_W'(i_x[X_W-1:3]);
    assign o_offset    = w_row_part + w_bank_part + w_byte_part;

    // The leftmost pixel of a byte is the most significant bit.
    assign o_mask = t_mask'(8'h80) >> i_x[2:0];
endmodule

// ===== hw/rtl/lrast_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lrast_checker
// Port-level checks of the rasterizer: output hold under stall, mask consistency
// with the column, no result from a start item, and command ready when empty.
// ============================================================================
module lrast_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cmd_valid,
    input logic               i_cmd_ready,
    input logic               i_cmd_operation,
    input logic               i_pix_valid,
    input logic               i_pix_ready,
    input lrast_pkg::t_xcoord i_pix_x,
    input lrast_pkg::t_ycoord i_pix_y,
    input lrast_pkg::t_offset i_pix_offset,
    input lrast_pkg::t_mask   i_pix_mask
);
    import lrast_pkg::*;

    // A stalled result keeps its payload.
    a_pix_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix_valid && !i_pix_ready) |=> (i_pix_valid && $stable(i_pix_x)
            && $stable(i_pix_y) && $stable(i_pix_offset)))
        else $error("pixel item changed while stalled");

    // The mask marks the pixel's column within its byte.
    a_mask_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid |-> (i_pix_mask == (t_mask'(8'h80) >> i_pix_x[2:0])))
        else $error("bit mask does not match pixel column");

    // A start item never produces a pixel.
    a_start_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && i_cmd_ready && (i_cmd_operation == OP_START)) |=> !i_pix_valid)
        else $error("pixel emitted after a start item");

    // The command side is never blocked while the output register is empty.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix_valid |-> i_cmd_ready)
        else $error("command stalled with an empty output register");
endmodule

bind line_rasterizer_interleaved_fb lrast_checker u_lrast_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cmd_valid     (i_cmd.valid),
    .i_cmd_ready     (i_cmd.ready),
    .i_cmd_operation (i_cmd.operation),
    .i_pix_valid     (o_pix.valid),
    .i_pix_ready     (o_pix.ready),
    .i_pix_x         (o_pix.pixel_x),
    .i_pix_y         (o_pix.pixel_y),
    .i_pix_offset    (o_pix.byte_offset),
    .i_pix_mask      (o_pix.bit_mask)
);
